[rtl/spsm_pkg.sv]
`timescale 1ns / 1ps
package spsm_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned IDX_W  = 64;

  // The coefficient reduction takes one stage per coefficient bit.
  // The multiplication takes one stage per scalar bit.
  localparam int unsigned RED_STAGES = WORD_W;
  localparam int unsigned MUL_STAGES = WORD_W;
  localparam int unsigned STAGES     = RED_STAGES + MUL_STAGES;

  localparam logic [IDX_W-1:0] REG_MODULUS = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_SCALAR  = IDX_W'(1);

  localparam logic [WORD_W-1:0] MODULUS_RESET = WORD_W'(2);
  localparam logic [WORD_W-1:0] SCALAR_RESET  = WORD_W'(0);

  typedef struct packed {
    logic              v;
    logic [WORD_W-1:0] exp;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] acc;
    logic              last;
  } stage_t;

endpackage

[rtl/spsm_pipe.sv]
`timescale 1ns / 1ps
module spsm_pipe (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [spsm_pkg::WORD_W:0]     nn,
  input  logic [spsm_pkg::WORD_W-1:0]   scalar,
  input  spsm_pkg::stage_t              in_stage,
  output spsm_pkg::stage_t              out_stage
);

  localparam int unsigned W = spsm_pkg::WORD_W;

  spsm_pkg::stage_t st [0:spsm_pkg::STAGES];

  assign st[0]     = in_stage;
  assign out_stage = st[spsm_pkg::STAGES];

  genvar k;
  generate
    for (k = 0; k < spsm_pkg::STAGES; k++) begin : g_stage
      spsm_pkg::stage_t nxt;

      if (k < spsm_pkg::RED_STAGES) begin : g_red
        // Shift in one coefficient bit, MSB first; the remainder stays below nn.
        logic [W:0]   t;
        logic [W:0]   r;
        always_comb begin
          t = {st[k].acc, st[k].a[W-1]};
          r = (t >= nn) ? (t - nn) : t;
          nxt      = st[k];
          if (k == spsm_pkg::RED_STAGES - 1) begin
            nxt.a   = r[W-1:0];
            nxt.acc = '0;
          end else begin
            nxt.a   = {st[k].a[W-2:0], 1'b0};
            nxt.acc = r[W-1:0];
          end
        end
      end else begin : g_mul
        // Double and add: t < 3*nn, so one of two subtractions brings it back.
        logic [W+1:0] t;
        logic [W+1:0] t1;
        logic [W+1:0] t2;
        logic [W+1:0] nn2;
        logic [W+1:0] r;
        always_comb begin
          t   = {1'b0, st[k].acc, 1'b0}
                + ((scalar[W-1-(k-spsm_pkg::RED_STAGES)]) ? {2'b00, st[k].a} : '0);
          nn2 = {nn, 1'b0};
          t1  = t - {1'b0, nn};
          t2  = t - nn2;
          if (t >= nn2) begin
            r = t2;
          end else if (t >= {1'b0, nn}) begin
            r = t1;
          end else begin
            r = t;
          end
          nxt     = st[k];
          nxt.acc = r[W-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          st[k+1].v <= 1'b0;
        end else if (en) begin
          st[k+1].v <= nxt.v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          st[k+1].exp  <= nxt.exp;
          st[k+1].a    <= nxt.a;
          st[k+1].acc  <= nxt.acc;
          st[k+1].last <= nxt.last;
        end
      end
    end
  endgenerate

endmodule

[rtl/sparse_poly_scalar_mul_mod_core.sv]
`timescale 1ns / 1ps
// Scales sparse polynomial terms by a configured scalar modulo a configured
// modulus: each item yields one result item with the same exponent, product
// (coefficient * scalar) mod modulus, keep set when the product is nonzero,
// and the last mark copied. A modulus of zero acts as 2^64. One item enters
// per clock while the output is not stalled; each result passes through a
// 64-stage bit-serial reduction of the coefficient followed by a 64-stage
// double-and-add multiplier, one bit per stage. A stalled output freezes the
// whole pipeline. Configuration writes are always taken and must only occur
// while no item is in flight.
module sparse_poly_scalar_mul_mod_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [spsm_pkg::IDX_W-1:0]        cfg_index,
  input  logic [spsm_pkg::WORD_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [spsm_pkg::WORD_W-1:0]       exponent,
  input  logic [spsm_pkg::WORD_W-1:0]       coefficient,
  input  logic                              last_term,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [spsm_pkg::WORD_W-1:0]       exponent_out,
  output logic [spsm_pkg::WORD_W-1:0]       product,
  output logic                              keep,
  output logic                              last_out
);

  logic [spsm_pkg::WORD_W-1:0] modulus;
  logic [spsm_pkg::WORD_W-1:0] scalar;
  logic [spsm_pkg::WORD_W:0]   nn;
  logic                        en;
  spsm_pkg::stage_t            in_stage;
  spsm_pkg::stage_t            out_stage;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= spsm_pkg::MODULUS_RESET;
      scalar  <= spsm_pkg::SCALAR_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == spsm_pkg::REG_MODULUS) begin
        modulus <= cfg_data;
      end else if (cfg_index == spsm_pkg::REG_SCALAR) begin
        scalar <= cfg_data;
      end
    end
  end

  assign nn = {(modulus == '0), modulus};

  assign en       = !(out_stage.v && out_stall);
  assign in_stall = !en;

  always_comb begin
    in_stage.v    = in_valid;
    in_stage.exp  = exponent;
    in_stage.a    = coefficient;
    in_stage.acc  = '0;
    in_stage.last = last_term;
  end

  spsm_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .nn        (nn),
    .scalar    (scalar),
    .in_stage  (in_stage),
    .out_stage (out_stage)
  );

  assign out_valid    = out_stage.v;
  assign exponent_out = out_stage.exp;
  assign product      = out_stage.acc;
  assign keep         = (out_stage.acc != '0);
  assign last_out     = out_stage.last;

endmodule

[rtl/spsm_checker.sv]
`timescale 1ns / 1ps
module spsm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [spsm_pkg::WORD_W-1:0] product,
  input logic                        keep
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_keep: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (keep == (product != '0)))
    else $error("keep does not match product");

  a_stall_cause: assert property (@(posedge clk)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item after reset");

endmodule

bind sparse_poly_scalar_mul_mod_core spsm_checker u_spsm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .product   (product),
  .keep      (keep)
);

[sim/sparse_poly_scalar_mul_mod_core_test.sv]
`timescale 1ns / 1ps
module sparse_poly_scalar_mul_mod_core_test;

  typedef struct packed {
    logic [spsm_pkg::WORD_W-1:0] exp;
    logic [spsm_pkg::WORD_W-1:0] coef;
    logic                        last;
  } term_t;

  typedef struct packed {
    logic [spsm_pkg::WORD_W-1:0] exp;
    logic [spsm_pkg::WORD_W-1:0] prod;
    logic                        keep;
    logic                        last;
  } scaled_t;

  localparam int unsigned PIPE_LATENCY = spsm_pkg::STAGES + 8;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [spsm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [spsm_pkg::WORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [spsm_pkg::WORD_W-1:0] exponent = '0;
  logic [spsm_pkg::WORD_W-1:0] coefficient = '0;
  logic last_term = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [spsm_pkg::WORD_W-1:0] exponent_out;
  logic [spsm_pkg::WORD_W-1:0] product;
  logic keep;
  logic last_out;

  term_t   pending_terms[$];
  scaled_t expected_terms[$];
  logic [spsm_pkg::WORD_W-1:0] ring_modulus = spsm_pkg::MODULUS_RESET;
  logic [spsm_pkg::WORD_W-1:0] ring_scalar  = spsm_pkg::SCALAR_RESET;
  int error_count = 0;
  longint unsigned cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_off_cycles = 0;
  bit hold_off_request = 1'b0;
  bit in_accepted = 1'b0;

  sparse_poly_scalar_mul_mod_core u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shift-and-subtract modular product with a 65-bit accumulator so the
  // doubling never overflows.
  function automatic scaled_t scale_term(term_t t);
    logic [64:0] acc;
    logic [spsm_pkg::WORD_W-1:0] x;
    logic [spsm_pkg::WORD_W-1:0] y;
    scaled_t r;
    acc = '0;
    r.exp = t.exp;
    r.last = t.last;
    if (ring_modulus == '0) begin
      r.prod = t.coef * ring_scalar;
    end else begin
      x = t.coef % ring_modulus;
      y = ring_scalar % ring_modulus;
      for (int i = spsm_pkg::WORD_W - 1; i >= 0; i--) begin
        acc = acc << 1;
        if (acc >= {1'b0, ring_modulus}) acc = acc - {1'b0, ring_modulus};
        if (y[i]) begin
          acc = acc + {1'b0, x};
          if (acc >= {1'b0, ring_modulus}) acc = acc - {1'b0, ring_modulus};
        end
      end
      r.prod = acc[spsm_pkg::WORD_W-1:0];
    end
    r.keep = (r.prod != '0);
    return r;
  endfunction

  // The driver offers items in bursts, with random gaps between them.
  // Acceptance is taken from the last rising edge, not from the current stall.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (in_valid) void'(pending_terms.pop_front());
      if (pending_terms.size() > 0 && (burst_left > 0 || gap_left == 0)) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 30);
        burst_left--;
        if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        in_valid <= 1'b1;
        exponent <= pending_terms[0].exp;
        coefficient <= pending_terms[0].coef;
        last_term <= pending_terms[0].last;
      end else begin
        if (gap_left > 0) gap_left--;
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_accepted = !rst && in_valid && !in_stall;
    if (in_accepted) begin
      expected_terms.push_back(scale_term({exponent, coefficient, last_term}));
    end
  end

  // The receiver stalls on its own pattern, with an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_off_request) begin
      hold_off_request = 1'b0;
      hold_off_cycles = 400;
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_stall <= 1'b1;
    end else if ((cycle_count / 64) % 3 == 0) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    scaled_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (expected_terms.size() == 0) begin
        $error("unexpected result item: exponent %h product %h", exponent_out, product);
        error_count++;
      end else begin
        e = expected_terms.pop_front();
        if (exponent_out !== e.exp) begin
          $error("exponent_out expected %h actual %h", e.exp, exponent_out);
          error_count++;
        end
        if (product !== e.prod) begin
          $error("product expected %h actual %h", e.prod, product);
          error_count++;
        end
        if (keep !== e.keep) begin
          $error("keep expected %b actual %b", e.keep, keep);
          error_count++;
        end
        if (last_out !== e.last) begin
          $error("last_out expected %b actual %b", e.last, last_out);
          error_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [spsm_pkg::IDX_W-1:0] idx,
                           input logic [spsm_pkg::WORD_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == spsm_pkg::REG_MODULUS) ring_modulus = value;
    else if (idx == spsm_pkg::REG_SCALAR) ring_scalar = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_terms.size() > 0 || in_valid || expected_terms.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [spsm_pkg::WORD_W-1:0] rand_word();
    logic [spsm_pkg::WORD_W-1:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: w = w >> $urandom_range(1, 63);
      1: w = ~(w >> $urandom_range(1, 63));
      default: ;
    endcase
    return w;
  endfunction

  function automatic term_t random_term();
    term_t t;
    t.exp = {$urandom, $urandom};
    t.coef = ($urandom_range(0, 3) == 0) ? rand_word() :
             ((ring_modulus == '0) ? rand_word() : rand_word() % ring_modulus);
    if ($urandom_range(0, 15) == 0) t.coef = '0;
    t.last = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  initial begin
    logic [spsm_pkg::WORD_W-1:0] mods[8];
    logic [spsm_pkg::WORD_W-1:0] scals[8];
    mods  = '{64'h0, 64'h1, 64'h2, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFC5,
              64'h8000_0000_0000_0000, 64'd97, 64'h0000_0001_0000_0003};
    scals = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd5, 64'h1, 64'hFFFF_FFFF_FFFF_FFFE,
              64'h0, 64'h8000_0000_0000_0001, 64'd1000, 64'h1234_5678_9ABC_DEF0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed items run at the reset setting, then at the extremes, then at modulus 7 with scalar 14.
    pending_terms.push_back('{64'h0, 64'h0, 1'b0});
    pending_terms.push_back('{'1, '1, 1'b1});
    drain();
    write_reg(spsm_pkg::REG_MODULUS, '0);
    write_reg(spsm_pkg::REG_SCALAR, '1);
    pending_terms.push_back('{64'h1, '1, 1'b0});
    pending_terms.push_back('{64'h2, 64'h0, 1'b1});
    pending_terms.push_back('{64'h3, 64'h1, 1'b0});
    drain();
    write_reg(spsm_pkg::REG_MODULUS, 64'h1);
    pending_terms.push_back('{'1, 64'h1234, 1'b1});
    pending_terms.push_back('{64'h0, '1, 1'b0});
    drain();
    write_reg(spsm_pkg::REG_MODULUS, '1);
    pending_terms.push_back('{64'h5, '1, 1'b0});
    pending_terms.push_back('{64'h6, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1});
    pending_terms.push_back('{64'h7, 64'h2, 1'b0});
    drain();
    write_reg(spsm_pkg::REG_MODULUS, 64'd7);
    write_reg(spsm_pkg::REG_SCALAR, 64'd14);
    pending_terms.push_back('{64'h8, 64'd3, 1'b0});
    pending_terms.push_back('{64'h9, 64'd100, 1'b1});
    drain();

    // Random phases, each under its own setting.
    for (int p = 0; p < 16; p++) begin
      write_reg(spsm_pkg::REG_MODULUS, (p < 8) ? mods[p] : rand_word());
      write_reg(spsm_pkg::REG_SCALAR, (p < 8) ? scals[p] : rand_word());
      for (int i = 0; i < 80; i++) pending_terms.push_back(random_term());
      if (p == 3 || p == 11) hold_off_request = 1'b1;
      drain();
    end

    repeat (PIPE_LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
